/* hw/rtl/wrm_pkg.sv */
// shared types, register indexes, mode codes and window constants
// for the window rank and mean filter; no dependencies
package wrm_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  localparam int CFG_W = 12;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [IDX_W-1:0] REG_MODE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BORDER = 3'd4;

  localparam logic [1:0] MODE_MEAN   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_MAX    = 2'd2;
  localparam logic [1:0] MODE_MIN    = 2'd3;

  localparam logic OP_PIXEL         = 1'b0;
  localparam logic OP_DRAIN         = 1'b1;
  localparam logic BORDER_ZERO      = 1'b0;
  localparam logic BORDER_REPLICATE = 1'b1;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_RADIUS = 3;

  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;
  localparam logic [1:0]  RST_RADIUS = 2'd1;

  localparam int RESULT_CAP = 4;
  localparam int SUM_W      = 14;
  localparam int RCP_SHIFT  = 20;
  localparam int RCP_W      = 21;

  // reciprocal of the window area, rounded up, scaled by 2^20
  function automatic logic [RCP_W-1:0] win_recip(input logic [1:0] rad);
    case (rad)
      2'd0: win_recip = 21'd1048576;
      2'd1: win_recip = 21'd116509;
      2'd2: win_recip = 21'd41944;
      default: win_recip = 21'd21400;
    endcase
  endfunction

  // middle position of the sorted window
  function automatic logic [5:0] win_mid(input logic [1:0] rad);
    case (rad)
      2'd0: win_mid = 6'd0;
      2'd1: win_mid = 6'd4;
      2'd2: win_mid = 6'd12;
      default: win_mid = 6'd24;
    endcase
  endfunction

  // last position of the sorted window
  function automatic logic [5:0] win_top(input logic [1:0] rad);
    case (rad)
      2'd0: win_top = 6'd0;
      2'd1: win_top = 6'd8;
      2'd2: win_top = 6'd24;
      default: win_top = 6'd48;
    endcase
  endfunction

endpackage

/* hw/rtl/wrm_store.sv */
// row store: single write port, registered read port
// depends on wrm_pkg
module wrm_store import wrm_pkg::*; #(
  parameter int DEPTH = 7 * DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pix_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output pix_t          rdata
);

  pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/wrm_cell.sv */
// one cell of the insertion sorting chain, three channels
// depends on wrm_pkg
module wrm_cell import wrm_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       insert,
  input  pix_t       x,
  input  pix_t       left_val,
  input  logic [2:0] left_keep,
  input  logic       left_valid,
  output pix_t       val,
  output logic [2:0] keep,
  output logic       valid
);

  pix_t val_next;

  // keep own value when it is not above the new one
  assign keep[2] = valid && (val.r <= x.r);
  assign keep[1] = valid && (val.g <= x.g);
  assign keep[0] = valid && (val.b <= x.b);

  always_comb begin
    val_next.r = keep[2] ? val.r : ((FIRST || left_keep[2]) ? x.r : left_val.r);
    val_next.g = keep[1] ? val.g : ((FIRST || left_keep[1]) ? x.g : left_val.g);
    val_next.b = keep[0] ? val.b : ((FIRST || left_keep[0]) ? x.b : left_val.b);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (insert) begin
      valid <= FIRST ? 1'b1 : left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      val <= val_next;
    end
  end

endmodule

/* hw/rtl/wrm_chain.sv */
// chain of sorting cells, ascending order, one insertion per cycle
// depends on wrm_pkg and wrm_cell
module wrm_chain import wrm_pkg::*; #(
  parameter int NCELL = 49
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic insert,
  input  pix_t x,
  output pix_t vals [NCELL]
);

  logic [2:0] keeps  [NCELL];
  logic       valids [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      wrm_cell #(.FIRST(1'b1)) u_cell (
        .clk(clk), .rst(rst), .clear(clear), .insert(insert), .x(x),
        .left_val(x), .left_keep(3'b000), .left_valid(1'b1),
        .val(vals[i]), .keep(keeps[i]), .valid(valids[i])
      );
    end else begin : g_body
      wrm_cell #(.FIRST(1'b0)) u_cell (
        .clk(clk), .rst(rst), .clear(clear), .insert(insert), .x(x),
        .left_val(vals[i-1]), .left_keep(keeps[i-1]), .left_valid(valids[i-1]),
        .val(vals[i]), .keep(keeps[i]), .valid(valids[i])
      );
    end
  end

endmodule

/* hw/rtl/window_rank_mean_filter.sv */
// window rank and mean filter: per-channel mean, median, max or min over a
// square window of a raster rgb stream, padded with zeros or edge copies
// a word is taken, then the input stalls while the m results that it
// releases (0 to 4) are computed and sent, output stalls included; at most
// one row store read per window position; one word at a time
// reset: synchronous, restores register defaults and starts a new frame
module window_rank_mean_filter import wrm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic             clk,
  input  logic             rst,
  // configuration writes
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // input words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  // output words
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic             row_end,
  output logic             frame_end,
  output logic             last_of_run
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int SROWS = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(SROWS);
  localparam int DEPTH = SROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  // the radius register is two bits wide, so the window never exceeds 7x7
  localparam int CR    = (MAX_RADIUS > 3) ? 3 : MAX_RADIUS;
  localparam int NCELL = (2 * CR + 1) * (2 * CR + 1);
  localparam logic [1:0] CR2 = CR[1:0];

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_SEND  = 3'd6;

  logic [2:0] state;

  // configuration registers
  logic [11:0] cfg_width, cfg_height;
  logic [1:0]  cfg_radius, cfg_mode;
  logic        cfg_border;

  // frame position counters; slots track row modulo store rows
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [SW-1:0] in_slot, out_slot;
  logic          in_done;
  logic [2:0]    k;
  logic          brk;

  // window walk
  logic signed [3:0] dy, dx;
  logic              issue_v, issue_zero;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [SUM_W+RCP_W-1:0] prod_r, prod_g, prod_b;

  // result waiting for the output handshake
  logic       pend_valid;
  pix_t       pend_pix;
  logic       pend_row_end, pend_frame_end, pend_last;

  // effective geometry
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;
  logic [1:0]    rad;

  always_comb begin
    if (cfg_width == 12'd0) begin
      wlast = '0;
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(cfg_width - 12'd1);
    end
    if (cfg_height == 12'd0) begin
      hlast = '0;
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      hlast = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast = RW'(cfg_height - 12'd1);
    end
    rad = (cfg_radius > CR2) ? CR2 : cfg_radius;
  end

  // readiness of the next output position: its lower right window corner
  // (clipped to the frame) has been stored, or the frame input is complete
  logic [RW:0] need_row;
  logic [CW:0] need_col;
  logic        ready, follow;

  always_comb begin
    need_row = {1'b0, out_row} + (RW+1)'(rad);
    if (need_row > {1'b0, hlast}) begin
      need_row = {1'b0, hlast};
    end
    need_col = {1'b0, out_col} + (CW+1)'(rad);
    if (need_col > {1'b0, wlast}) begin
      need_col = {1'b0, wlast};
    end
    ready = in_done || ({1'b0, in_row} > need_row) ||
            ({1'b0, in_row} == need_row && {1'b0, in_col} > need_col);
    follow = (k < 3'(RESULT_CAP)) && !brk && ready;
  end

  // window address: clamp or flag as zero padding, then map row to slot
  logic          rd_zero;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          last_tap;

  always_comb begin
    int yi, xi, t;
    yi = int'(out_row) + int'(dy);
    xi = int'(out_col) + int'(dx);
    rd_zero = (cfg_border == BORDER_ZERO) &&
              (yi < 0 || yi > int'(hlast) || xi < 0 || xi > int'(wlast));
    if (yi < 0) yi = 0;
    if (yi > int'(hlast)) yi = int'(hlast);
    if (xi < 0) xi = 0;
    if (xi > int'(wlast)) xi = int'(wlast);
    t = int'(out_slot) + (yi - int'(out_row)) + SROWS;
    if (t >= SROWS) t = t - SROWS;
    if (t >= SROWS) t = t - SROWS;
    rd_addr  = AW'(t * MAX_WIDTH + xi);
    wr_addr  = AW'(int'(in_slot) * MAX_WIDTH + int'(in_col));
    last_tap = (dy == $signed({2'b00, rad})) && (dx == $signed({2'b00, rad}));
  end

  logic accept, pixel_write;
  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign pixel_write = accept && (operation == OP_PIXEL) && !in_done;

  pix_t in_pix, rdata, tap;
  assign in_pix = '{r: red_in, g: green_in, b: blue_in};

  wrm_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(pixel_write), .waddr(wr_addr), .wdata(in_pix),
    .re(state == S_FETCH && !rd_zero), .raddr(rd_addr), .rdata(rdata)
  );

  assign tap = issue_zero ? '0 : rdata;

  pix_t sorted [NCELL];

  wrm_chain #(.NCELL(NCELL)) u_chain (
    .clk(clk), .rst(rst), .clear(state == S_CHECK), .insert(issue_v),
    .x(tap), .vals(sorted)
  );

  // selection of the reduced value
  pix_t lo_pix, mid_pix, hi_pix, res_pix;
  always_comb begin
    lo_pix  = sorted[0];
    mid_pix = sorted[win_mid(rad)];
    hi_pix  = sorted[win_top(rad)];
    case (cfg_mode)
      MODE_MEAN: begin
        res_pix = '{r: prod_r[RCP_SHIFT +: 8], g: prod_g[RCP_SHIFT +: 8],
                    b: prod_b[RCP_SHIFT +: 8]};
      end
      MODE_MEDIAN: res_pix = mid_pix;
      MODE_MAX:    res_pix = hi_pix;
      MODE_MIN:    res_pix = lo_pix;
      default:     res_pix = lo_pix;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_width  <= RST_WIDTH;
      cfg_height <= RST_HEIGHT;
      cfg_radius <= RST_RADIUS;
      cfg_mode   <= MODE_MEAN;
      cfg_border <= BORDER_ZERO;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      in_done    <= 1'b0;
      k          <= '0;
      brk        <= 1'b0;
      issue_v    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      issue_v <= (state == S_FETCH);
      if (cfg_write && cfg_index <= REG_BORDER) begin
        case (cfg_index)
          REG_WIDTH:  cfg_width  <= cfg_data;
          REG_HEIGHT: cfg_height <= cfg_data;
          REG_RADIUS: cfg_radius <= cfg_data[1:0];
          REG_MODE:   cfg_mode   <= cfg_data[1:0];
          default:    cfg_border <= cfg_data[0];
        endcase
        // any register write restarts the frame
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
        in_done  <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (pixel_write) begin
              if (in_col == wlast) begin
                in_col <= '0;
                if (in_row == hlast) begin
                  in_row  <= '0;
                  in_slot <= '0;
                  in_done <= 1'b1;
                end else begin
                  in_row  <= in_row + 1'b1;
                  in_slot <= (int'(in_slot) == SROWS - 1) ? '0 : in_slot + 1'b1;
                end
              end else begin
                in_col <= in_col + 1'b1;
              end
            end
            k     <= '0;
            brk   <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pend_valid) begin
            // last word of the run once nothing else can follow
            pend_last <= !follow;
            state     <= S_SEND;
          end else if (follow) begin
            dy    <= -$signed({2'b00, rad});
            dx    <= -$signed({2'b00, rad});
            state <= S_FETCH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (dx == $signed({2'b00, rad})) begin
            dx <= -$signed({2'b00, rad});
            dy <= dy + 4'sd1;
          end else begin
            dx <= dx + 4'sd1;
          end
          if (last_tap) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_MUL;
        S_MUL:   state <= S_FIN;
        S_FIN: begin
          pend_valid <= 1'b1;
          k          <= k + 1'b1;
          if (out_col == wlast && out_row == hlast) begin
            brk      <= 1'b1;
            in_col   <= '0;
            in_row   <= '0;
            in_slot  <= '0;
            out_col  <= '0;
            out_row  <= '0;
            out_slot <= '0;
            in_done  <= 1'b0;
          end else if (out_col == wlast) begin
            out_col  <= '0;
            out_row  <= out_row + 1'b1;
            out_slot <= (int'(out_slot) == SROWS - 1) ? '0 : out_slot + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
          state <= S_CHECK;
        end
        S_SEND: begin
          if (!out_stall) begin
            pend_valid <= 1'b0;
            state      <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    issue_zero <= rd_zero;
    if (state == S_CHECK) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (issue_v) begin
      sum_r <= sum_r + SUM_W'(tap.r);
      sum_g <= sum_g + SUM_W'(tap.g);
      sum_b <= sum_b + SUM_W'(tap.b);
    end
    if (state == S_MUL) begin
      prod_r <= sum_r * win_recip(rad);
      prod_g <= sum_g * win_recip(rad);
      prod_b <= sum_b * win_recip(rad);
    end
    if (state == S_FIN) begin
      pend_pix       <= res_pix;
      pend_row_end   <= (out_col == wlast);
      pend_frame_end <= (out_col == wlast && out_row == hlast);
    end
  end

  assign out_valid   = (state == S_SEND);
  assign red_out     = pend_pix.r;
  assign green_out   = pend_pix.g;
  assign blue_out    = pend_pix.b;
  assign row_end     = pend_row_end;
  assign frame_end   = pend_frame_end;
  assign last_of_run = pend_last;

  // no more than four results per word
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    k <= 3'(RESULT_CAP))
    else $error("result count above cap");

  // a word is only shown while a computed result is held
  a_send_pend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend_valid)
    else $error("output without pending result");

  // a register write in the idle state restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index <= REG_BORDER && state == S_IDLE) |=>
      (in_row == '0 && out_row == '0 && !in_done))
    else $error("frame not restarted on register write");

  // a result run never ends up with a frame end that is not last of run
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> last_of_run)
    else $error("frame end not last of run");

endmodule

/* tb/sv/tb_window_rank_mean_filter.sv */
// testbench for the window rank and mean filter: drives pixel and drain words,
// predicts every filtered pixel with a behavioural window model, checks outputs
// depends on wrm_pkg and window_rank_mean_filter
module tb_window_rank_mean_filter import wrm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = 2 * DEF_MAX_RADIUS + 1;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       row_end;
    logic       frame_end;
    logic       last;
  } filt_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_PIXEL;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out, green_out, blue_out;
  logic row_end, frame_end, last_of_run;

  window_rank_mean_filter dut (.*);

  // predictor state: registers, frame counters and a copy of the row store
  logic [11:0] p_width, p_height;
  logic [1:0]  p_radius, p_mode;
  logic        p_border;
  int          in_col, in_row, out_col, out_row;
  bit          in_done;
  pix_t        rows [STORE_ROWS][DEF_MAX_WIDTH];

  filt_word_t  pending_pixels [$];
  int          send_idle_pct, recv_stall_pct;
  int          errors = 0;
  longint      cycles = 0;

  initial forever #4 clk = ~clk;

  // watchdog on a cycle counter
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall, random per phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // output checker: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    filt_word_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{red_out, green_out, blue_out, row_end, frame_end, last_of_run};
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  function automatic int eff_w();
    return (p_width == 0) ? 1 : ((p_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : p_width);
  endfunction

  function automatic int eff_h();
    return (p_height == 0) ? 1 : ((p_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : p_height);
  endfunction

  function automatic void new_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 0;
  endfunction

  function automatic bit window_complete(int w, int h, int rad);
    int nr, nc;
    if (in_done) return 1;
    nr = out_row + rad; if (nr > h - 1) nr = h - 1;
    nc = out_col + rad; if (nc > w - 1) nc = w - 1;
    return in_row > nr || (in_row == nr && in_col > nc);
  endfunction

  function automatic pix_t window_pixel(int y, int x, int w, int h);
    if (y < 0 || y >= h || x < 0 || x >= w) begin
      if (p_border == BORDER_ZERO) return '0;
      if (y < 0) y = 0;
      if (y >= h) y = h - 1;
      if (x < 0) x = 0;
      if (x >= w) x = w - 1;
    end
    return rows[y % STORE_ROWS][x];
  endfunction

  // reduce one channel of the window according to the filter mode
  function automatic logic [7:0] reduce_channel(logic [7:0] v [], int n);
    int acc;
    logic [7:0] t;
    case (p_mode)
      MODE_MEAN: begin
        acc = 0;
        foreach (v[i]) acc += v[i];
        return 8'(acc / n);
      end
      MODE_MEDIAN: begin
        for (int i = 1; i < n; i++)
          for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
            t = v[j]; v[j] = v[j-1]; v[j-1] = t;
          end
        return v[n/2];
      end
      default: begin
        acc = v[0];
        for (int i = 1; i < n; i++)
          if (p_mode == MODE_MAX ? v[i] > acc : v[i] < acc) acc = v[i];
        return 8'(acc);
      end
    endcase
  endfunction

  function automatic filt_word_t filter_at(int w, int h, int rad);
    logic [7:0] cr [], cg [], cb [];
    int n, side;
    pix_t p;
    filt_word_t o;
    side = 2 * rad + 1;
    cr = new[side * side]; cg = new[side * side]; cb = new[side * side];
    n = 0;
    for (int dy = -rad; dy <= rad; dy++)
      for (int dx = -rad; dx <= rad; dx++) begin
        p = window_pixel(out_row + dy, out_col + dx, w, h);
        cr[n] = p.r; cg[n] = p.g; cb[n] = p.b;
        n++;
      end
    o.r = reduce_channel(cr, n);
    o.g = reduce_channel(cg, n);
    o.b = reduce_channel(cb, n);
    o.row_end = (out_col == w - 1);
    o.frame_end = o.row_end && (out_row == h - 1);
    o.last = 1'b0;
    return o;
  endfunction

  // advance the predictor by one accepted word and queue what it releases
  function automatic void predict_word(logic op, pix_t px);
    int w, h, rad, k;
    filt_word_t o;
    w = eff_w(); h = eff_h(); rad = p_radius;
    if (op == OP_PIXEL && !in_done) begin
      rows[in_row % STORE_ROWS][in_col] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
        if (in_row >= h) begin in_row = 0; in_done = 1; end
      end
    end
    k = 0;
    while (k < RESULT_CAP && window_complete(w, h, rad)) begin
      o = filter_at(w, h, rad);
      k++;
      pending_pixels.push_back(o);
      if (o.frame_end) begin
        new_frame();
        break;
      end
      out_col++;
      if (out_col >= w) begin out_col = 0; out_row++; end
    end
    if (k > 0) pending_pixels[pending_pixels.size()-1].last = 1'b1;
  endfunction

  task automatic send_word(logic op, pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    red_in <= px.r; green_in <= px.g; blue_in <= px.b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, px);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    // a drain may still be busy after the last result, allow a window pass
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH:  p_width = val;
      REG_HEIGHT: p_height = val;
      REG_RADIUS: p_radius = val[1:0];
      REG_MODE:   p_mode = val[1:0];
      default:    p_border = val[0];
    endcase
    new_frame();
  endtask

  task automatic setup(int w, int h, int rad, logic [1:0] mode, logic brd);
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    write_reg(REG_RADIUS, CFG_W'(rad));
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_BORDER, CFG_W'(brd));
  endtask

  function automatic pix_t rand_pixel();
    return pix_t'(24'($urandom_range(24'hFFFFFF)));
  endfunction

  // whole frame with occasional early drains, then drains until every result is out
  task automatic run_frame(int w, int h, bit extremes);
    pix_t px;
    int total;
    total = w * h;
    for (int i = 0; i < total; i++) begin
      if (extremes) px = (i % 2) ? 24'hFFFFFF : 24'h000000;
      else px = rand_pixel();
      // occasional early drain; usually releases nothing
      if ($urandom_range(19) == 0) send_word(OP_DRAIN, rand_pixel());
      send_word(OP_PIXEL, px);
    end
    while (in_done) send_word(OP_DRAIN, rand_pixel());
  endtask

  // directed: extreme values, every mode, both borders, degenerate sizes
  task automatic test_directed();
    setup(3, 3, 1, MODE_MEAN, BORDER_ZERO);
    run_frame(3, 3, 1);
    quiesce();
    setup(1, 1, 0, MODE_MEDIAN, BORDER_REPLICATE);
    send_word(OP_PIXEL, 24'hFFFFFF);
    send_word(OP_PIXEL, 24'h5AA5C3);
    quiesce();
    // zero sizes behave as one
    setup(0, 0, 3, MODE_MAX, BORDER_ZERO);
    send_word(OP_PIXEL, 24'h123456);
    quiesce();
    setup(2, 2, 3, MODE_MIN, BORDER_REPLICATE);
    run_frame(2, 2, 0);
    quiesce();
  endtask

  // a pixel after the frame is complete is dropped while results still flow
  task automatic test_after_frame();
    setup(4, 2, 2, MODE_MEDIAN, BORDER_ZERO);
    for (int i = 0; i < 8; i++) send_word(OP_PIXEL, rand_pixel());
    send_word(OP_PIXEL, 24'hFFFFFF);
    while (in_done) send_word(OP_DRAIN, '0);
    quiesce();
  endtask

  // random frames over all modes, borders and radii
  task automatic test_random(int words);
    int sent, w, h;
    sent = 0;
    while (sent < words) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      setup(w, h, int'($urandom_range(3)), 2'($urandom_range(3)),
            1'($urandom_range(1)));
      run_frame(w, h, 0);
      quiesce();
      sent += w * h;
    end
  endtask

  initial begin
    p_width = RST_WIDTH; p_height = RST_HEIGHT; p_radius = RST_RADIUS;
    p_mode = MODE_MEAN; p_border = BORDER_ZERO;
    new_frame();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset defaults, a small frame with the 640 width would be slow; just
    // check that a drain alone releases nothing
    send_word(OP_DRAIN, '0);
    quiesce();
    test_directed();
    test_after_frame();
    test_random(60);
    send_idle_pct = 45;
    test_random(60);
    send_idle_pct = 0; recv_stall_pct = 45;
    test_random(60);
    send_idle_pct = 11; recv_stall_pct = 11;
    test_random(60);
    // largest width once
    send_idle_pct = 0; recv_stall_pct = 0;
    setup(2048, 1, 3, MODE_MAX, BORDER_REPLICATE);
    for (int i = 0; i < 4; i++) send_word(OP_PIXEL, rand_pixel());
    quiesce();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
